/* src/arp_cache_engine_macros.svh */
// ----------------------------------------------------------------------------
// arp_cache_engine_macros
// concurrent assertion helpers for the arp cache engine
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_ENGINE_MACROS_SVH
`define ARP_CACHE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define ACE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ACE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ACE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ACE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/ace_pkg.sv */
// ----------------------------------------------------------------------------
// ace_pkg
// types, codes and helpers shared by the arp cache engine
// ----------------------------------------------------------------------------
package ace_pkg;
    localparam int NumBucketsDef = 11;
    localparam int BucketWaysDef = 5;
    localparam int HandleBitsDef = 8;

    localparam logic [1:0] ACT_RESOLVE = 2'd0;
    localparam logic [1:0] ACT_LEARN   = 2'd1;
    localparam logic [1:0] ACT_DELETE  = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    localparam logic [2:0] K_RESOLVED = 3'd0;
    localparam logic [2:0] K_PENDING  = 3'd1;
    localparam logic [2:0] K_REQUEST  = 3'd2;
    localparam logic [2:0] K_DISCARD  = 3'd3;
    localparam logic [2:0] K_SENDHELD = 3'd4;
    localparam logic [2:0] K_REPLY    = 3'd5;
    localparam logic [2:0] K_DROP     = 3'd6;
    localparam logic [2:0] K_DONE     = 3'd7;

    localparam logic [2:0] REG_OWN_IP  = 3'd0;
    localparam logic [2:0] REG_OWN_HW  = 3'd1;
    localparam logic [2:0] REG_PROTO   = 3'd2;
    localparam logic [2:0] REG_HLEN    = 3'd3;
    localparam logic [2:0] REG_KILLC   = 3'd4;
    localparam logic [2:0] REG_KILLI   = 3'd5;
    localparam logic [2:0] REG_PERIOD  = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] ip_addr;
        logic [47:0] sender_hw;
        logic [31:0] target_ip;
        logic        is_request;
        logic        target_is_ours;
        logic [15:0] proto_type;
        logic [7:0]  packet_handle;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_ip;
        logic [47:0] out_hw;
        logic [31:0] claimed_ip;
        logic [7:0]  out_handle;
        logic        last;
    } t_out_word;

    // one table entry
    typedef struct packed {
        logic        in_use;
        logic        complete;
        logic        holding;
        logic [7:0]  age;
        logic [31:0] ip;
        logic [47:0] hw;
        logic [7:0]  tag;
    } t_entry;

    // command from the sequencer to every cell
    typedef struct packed {
        logic        shift;      // rotate ring by one
        logic        wr_head;    // write head cell with wr_data
    } t_ring_ctl;

    function automatic logic [47:0] hw_mask(input logic [2:0] len);
        logic [47:0] m;
        m = '0;
        case (len)
            3'd0, 3'd1: m = 48'h0000_0000_00FF;
            3'd2:       m = 48'h0000_0000_FFFF;
            3'd3:       m = 48'h0000_00FF_FFFF;
            3'd4:       m = 48'h0000_FFFF_FFFF;
            3'd5:       m = 48'h00FF_FFFF_FFFF;
            default:    m = 48'hFFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic t_out_word mk_out(input logic [2:0] k, input logic [31:0] ip,
                                         input logic [47:0] hw, input logic [31:0] cl,
                                         input logic [7:0] h, input logic l);
        t_out_word o;
        o.kind = k;
        o.out_ip = ip;
        o.out_hw = hw;
        o.claimed_ip = cl;
        o.out_handle = h;
        o.last = l;
        return o;
    endfunction
endpackage

/* src/ace_cell.sv */
// ----------------------------------------------------------------------------
// ace_cell
// one entry of the table ring: holds an entry, hands it to the next cell
// ----------------------------------------------------------------------------
module ace_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ace_pkg::t_ring_ctl i_ctl,
    input  logic            i_is_head,
    input  ace_pkg::t_entry i_prev,
    input  ace_pkg::t_entry i_wr_data,
    output ace_pkg::t_entry o_entry
);
    import ace_pkg::*;

    t_entry r_e;
    t_entry n_e;

    always_comb begin
        n_e = r_e;
        if (i_ctl.shift) begin
            n_e = i_prev;
            if (i_is_head && i_ctl.wr_head) begin
                n_e = i_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.in_use   <= 1'b0;
            r_e.complete <= 1'b0;
            r_e.holding  <= 1'b0;
            r_e.age      <= '0;
            r_e.ip       <= '0;
        end else begin
            r_e.in_use   <= n_e.in_use;
            r_e.complete <= n_e.complete;
            r_e.holding  <= n_e.holding;
            r_e.age      <= n_e.age;
            r_e.ip       <= n_e.ip;
        end
        r_e.hw  <= n_e.hw;
        r_e.tag <= n_e.tag;
    end

    assign o_entry = r_e;
endmodule

/* src/arp_cache_engine.sv */
// ----------------------------------------------------------------------------
// arp_cache_engine
// hashed bucketed ip to hardware address cache with aging
// ----------------------------------------------------------------------------
// usage: pulse start with a command word on i_cmd while busy is low; the
// word is taken at that edge. results come out on o_res, one word per cycle
// flagged by o_res_valid, the final word of each command carries last = 1.
// the receiver cannot stall; every result is seen for one cycle only.
// the table lives in a ring of NUM_BUCKETS*BUCKET_WAYS cells that rotates by
// one entry per cycle past a head cell while a command scans or edits. a
// command first reduces its hash by 0 to 40 subtract steps, rotates the ring
// once to find the hit and replacement way (N = table size, 55 by default),
// decides, rotates again editing at the head and ends, giving a queued
// request word first when one is still pending. the final word shows once
// busy has dropped; a new command may be taken in the cycle the final word
// is shown.
// config writes on i_cfg_we/i_cfg_idx/i_cfg_data land at once; the user must
// make them only while the block is idle, the block itself does not enforce
// it. synchronous reset clears the table flags, the tick counter and the
// registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "arp_cache_engine_macros.svh"
module arp_cache_engine #(
    parameter int NUM_BUCKETS = ace_pkg::NumBucketsDef,
    parameter int BUCKET_WAYS = ace_pkg::BucketWaysDef,
    parameter int HANDLE_BITS = ace_pkg::HandleBitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ace_pkg::t_in_word i_cmd,
    output logic              o_res_valid,
    output ace_pkg::t_out_word o_res,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [47:0]       i_cfg_data
);
    import ace_pkg::*;

    localparam int N  = NUM_BUCKETS * BUCKET_WAYS;
    localparam int PW = (N > 1) ? $clog2(N + 1) : 1;
    localparam logic [7:0] HMASK = 8'((32'd1 << HANDLE_BITS) - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;

    // configuration
    logic [31:0] r_own_ip;
    logic [47:0] r_own_hw;
    logic [15:0] r_proto;
    logic [2:0]  r_hlen;
    logic [7:0]  r_killc, r_killi, r_period, r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
            r_own_hw <= '0;
            r_proto  <= 16'd2048;
            r_hlen   <= 3'd6;
            r_killc  <= 8'd20;
            r_killi  <= 8'd3;
            r_period <= 8'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OWN_IP: r_own_ip <= i_cfg_data[31:0];
                REG_OWN_HW: r_own_hw <= i_cfg_data;
                REG_PROTO:  r_proto  <= i_cfg_data[15:0];
                REG_HLEN:   r_hlen   <= i_cfg_data[2:0];
                REG_KILLC:  r_killc  <= i_cfg_data[7:0];
                REG_KILLI:  r_killi  <= i_cfg_data[7:0];
                REG_PERIOD: r_period <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ring of cells, head is cell 0, entry at head has index r_pos
    // the edited head entry is written into the last cell as the ring turns
    t_ring_ctl w_ctl;
    t_entry    w_wr;
    t_entry    w_ent [N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        ace_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_is_head(g == N - 1),
            .i_prev   (w_ent[(g + 1) % N]),
            .i_wr_data(w_wr),
            .o_entry  (w_ent[g])
        );
    end

    t_entry w_head;
    assign w_head = w_ent[0];

    logic [2:0]    r_st, n_st;
    t_in_word      r_cmd;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_pass, n_pass;
    logic [PW-1:0] r_base;
    logic [16:0]   r_hx;
    logic          r_hit, n_hit;
    logic [PW-1:0] r_hidx, n_hidx;
    logic          r_free, n_free;
    logic [PW-1:0] r_pick, n_pick;
    logic [7:0]    r_old, n_old;
    logic          r_aging;
    logic          r_did;      // reply/drop decision flags
    logic [2:0]    r_fk;       // final kind for learn
    logic          r_mk;       // learn creates entry
    logic          r_ov, n_ov;
    t_out_word     r_o, n_o;
    logic          r_pend, n_pend;  // second word for resolve tail
    t_out_word     r_po, n_po;

    logic [47:0] w_m, w_sha;
    logic        w_in_bkt;
    assign w_m   = hw_mask(r_hlen);
    assign w_sha = r_cmd.sender_hw & w_m;
    assign w_in_bkt = (r_pos >= r_base) && (r_pos < r_base + PW'(BUCKET_WAYS));

    logic [7:0] w_hand;
    assign w_hand = r_cmd.packet_handle & HMASK;

    logic [7:0] w_age_inc, w_lim;
    assign w_age_inc = (w_head.age == 8'hFF) ? 8'hFF : w_head.age + 8'd1;
    assign w_lim     = w_head.complete ? r_killc : r_killi;

    logic w_bcast;
    assign w_bcast = (r_cmd.ip_addr[7:0] == 8'h00) || (r_cmd.ip_addr[7:0] == 8'hFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_pos <= '0; r_ov <= 1'b0; r_pend <= 1'b0; r_tick <= '0;
            r_pass <= 1'b0; r_hit <= 1'b0; r_free <= 1'b0;
        end else begin
            r_st <= n_st; r_pos <= n_pos; r_ov <= n_ov; r_pend <= n_pend;
            r_pass <= n_pass; r_hit <= n_hit; r_free <= n_free;
            if (r_st == S_DEC && r_cmd.action == ACT_TICK) begin
                r_tick <= (r_tick < r_period) ? r_tick + 8'd1 : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hidx <= n_hidx; r_pick <= n_pick; r_old <= n_old; r_o <= n_o; r_po <= n_po;
        if (start && !busy) begin
            r_cmd <= i_cmd;
            r_hx  <= {2'b00, i_cmd.ip_addr[30:16] ^ i_cmd.ip_addr[14:0]};
        end else if (r_st == S_HASH) begin
            if (r_hx >= 17'(NUM_BUCKETS)) begin
                r_hx <= r_hx - 17'(NUM_BUCKETS) * ((r_hx >= 17'(NUM_BUCKETS * 256)) ?
                        17'd256 : (r_hx >= 17'(NUM_BUCKETS * 16)) ? 17'd16 : 17'd1);
            end else begin
                r_base <= PW'(r_hx) * PW'(BUCKET_WAYS);
            end
        end
        if (r_st == S_DEC) begin
            r_aging <= (r_tick >= r_period);
            if (r_cmd.action == ACT_LEARN) begin
                r_did <= (r_cmd.proto_type == r_proto) && (w_sha != (r_own_hw & w_m))
                         && (r_cmd.ip_addr != r_own_ip);
                r_mk  <= !r_hit && ((r_cmd.target_ip == r_own_ip) || r_cmd.target_is_ours);
                r_fk  <= ((r_cmd.target_ip == r_own_ip) || r_cmd.target_is_ours)
                         && r_cmd.is_request ? K_REPLY : K_DROP;
            end else begin
                r_mk <= 1'b0; r_did <= 1'b0; r_fk <= K_DROP;
            end
        end
    end

    // sequencer: S_SCAN rotates once and finds hit/victim, S_DEC decides,
    // S_APPLY rotates once more, editing at the head, S_END gives last word
    always_comb begin
        t_entry e;
        logic   tgt, rsv_new;
        n_st = r_st; n_pos = r_pos; n_pass = r_pass;
        n_hit = r_hit; n_hidx = r_hidx; n_free = r_free; n_pick = r_pick; n_old = r_old;
        n_ov = 1'b0; n_o = r_o; n_pend = 1'b0; n_po = r_po;
        w_ctl = '0; w_wr = w_head;
        e = w_head;
        tgt = (r_pos == r_hidx && r_hit) || (r_pos == r_pick && !r_hit);
        rsv_new = 1'b0;
        if (r_pend) begin
            n_ov = 1'b1; n_o = r_po;
        end
        case (r_st)
            S_IDLE: if (start) n_st = S_HASH;
            S_HASH: if (r_hx < 17'(NUM_BUCKETS)) begin
                n_st = S_SCAN; n_hit = 1'b0; n_free = 1'b0; n_old = '0;
                n_pick = '0; n_hidx = '0; n_pass = 1'b0;
            end
            S_SCAN: begin
                w_ctl.shift = 1'b1;
                n_pos = (r_pos == PW'(N - 1)) ? '0 : r_pos + 1'b1;
                if (w_in_bkt && r_pos == r_base) begin
                    n_pick = r_pos;
                end
                if (w_in_bkt && !r_hit && w_head.in_use && w_head.ip == r_cmd.ip_addr
                    && !(r_hidx != '0 && r_pass)) begin
                    n_hit = 1'b1; n_hidx = r_pos; n_pass = 1'b1;
                end
                if (w_in_bkt && !r_free) begin
                    if (!w_head.in_use) begin
                        n_free = 1'b1; n_pick = r_pos;
                    end else if (w_head.age > r_old) begin
                        n_old = w_head.age; n_pick = r_pos;
                    end
                end
                if (n_pos == '0) n_st = S_DEC;
            end
            S_DEC: n_st = S_APPLY;
            S_APPLY: begin
                w_ctl.shift = 1'b1;
                n_pos = (r_pos == PW'(N - 1)) ? '0 : r_pos + 1'b1;
                if (n_pos == '0) n_st = S_END;
                case (r_cmd.action)
                    ACT_RESOLVE: if (!w_bcast && tgt && w_in_bkt) begin
                        if (r_hit && e.complete) begin
                            e.age = '0;
                        end else begin
                            rsv_new = !r_hit;
                            if (e.holding) begin
                                n_ov = 1'b1;
                                n_o = mk_out(K_DISCARD, e.ip, '0, '0, e.tag, 1'b0);
                            end
                            if (rsv_new) begin
                                e.ip = r_cmd.ip_addr; e.in_use = 1'b1; e.complete = 1'b0;
                            end
                            e.age = '0; e.holding = 1'b1; e.tag = w_hand;
                            if (n_ov) begin
                                n_pend = 1'b1;
                                n_po = mk_out(K_REQUEST, r_cmd.ip_addr, w_m, r_own_ip,
                                              '0, 1'b0);
                            end else begin
                                n_ov = 1'b1;
                                n_o = mk_out(K_REQUEST, r_cmd.ip_addr, w_m, r_own_ip,
                                             '0, 1'b0);
                            end
                        end
                        w_ctl.wr_head = 1'b1; w_wr = e;
                    end
                    ACT_LEARN: if (r_did && w_in_bkt) begin
                        if (r_hit && r_pos == r_hidx) begin
                            e.hw = w_sha; e.complete = 1'b1;
                            if (e.holding) begin
                                e.holding = 1'b0; n_ov = 1'b1;
                                n_o = mk_out(K_SENDHELD, r_cmd.ip_addr, w_sha, '0,
                                             e.tag, 1'b0);
                            end
                        end else if (r_mk && r_pos == r_pick) begin
                            if (!r_free && e.holding) begin
                                n_ov = 1'b1;
                                n_o = mk_out(K_DISCARD, e.ip, '0, '0, e.tag, 1'b0);
                            end
                            e.ip = r_cmd.ip_addr; e.in_use = 1'b1; e.complete = 1'b1;
                            e.holding = 1'b0; e.age = '0; e.hw = w_sha;
                        end
                        w_ctl.wr_head = 1'b1; w_wr = e;
                    end
                    ACT_DELETE: if (r_hit && r_pos == r_hidx) begin
                        if (e.holding) begin
                            n_ov = 1'b1;
                            n_o = mk_out(K_DISCARD, e.ip, '0, '0, e.tag, 1'b0);
                        end
                        e.in_use = 1'b0; e.complete = 1'b0; e.holding = 1'b0;
                        e.age = '0; e.ip = '0;
                        w_ctl.wr_head = 1'b1; w_wr = e;
                    end
                    default: if (r_aging && e.in_use) begin
                        e.age = w_age_inc;
                        if (w_age_inc >= w_lim) begin
                            if (e.holding) begin
                                n_ov = 1'b1;
                                n_o = mk_out(K_DISCARD, e.ip, '0, '0, e.tag, 1'b0);
                            end
                            e.in_use = 1'b0; e.complete = 1'b0; e.holding = 1'b0;
                            e.age = '0; e.ip = '0;
                        end
                        w_ctl.wr_head = 1'b1; w_wr = e;
                    end
                endcase
            end
            S_END: begin
                if (!r_pend) begin
                    n_st = S_IDLE; n_ov = 1'b1;
                    case (r_cmd.action)
                        ACT_RESOLVE: begin
                            if (w_bcast) begin
                                n_o = mk_out(K_RESOLVED, r_cmd.ip_addr, w_m, '0, '0, 1'b1);
                            end else if (r_hit && r_o.kind == K_RESOLVED) begin
                                n_o = r_o;
                            end else begin
                                n_o = mk_out(K_PENDING, r_cmd.ip_addr, '0, '0, w_hand, 1'b1);
                            end
                        end
                        ACT_LEARN: begin
                            if (r_cmd.proto_type != r_proto || w_sha == (r_own_hw & w_m)) begin
                                n_o = mk_out(K_DROP, '0, '0, '0, w_hand, 1'b1);
                            end else if (r_cmd.ip_addr == r_own_ip) begin
                                n_o = r_cmd.is_request ?
                                    mk_out(K_REPLY, r_cmd.ip_addr, w_sha, r_own_ip, w_hand, 1'b1) :
                                    mk_out(K_DROP, '0, '0, '0, w_hand, 1'b1);
                            end else if (r_fk == K_REPLY) begin
                                n_o = mk_out(K_REPLY, r_cmd.ip_addr, w_sha, r_cmd.target_ip,
                                             w_hand, 1'b1);
                            end else begin
                                n_o = mk_out(K_DROP, '0, '0, '0, w_hand, 1'b1);
                            end
                        end
                        default: n_o = mk_out(K_DONE, '0, '0, '0, '0, 1'b1);
                    endcase
                end
            end
            default: n_st = S_IDLE;
        endcase
        // a complete hit on resolve gives the resolved word at the end
        if (r_st == S_APPLY && r_cmd.action == ACT_RESOLVE && !w_bcast && r_hit
            && r_pos == r_hidx && w_head.complete) begin
            n_o = mk_out(K_RESOLVED, r_cmd.ip_addr, w_head.hw & w_m, '0, '0, 1'b1);
            n_ov = 1'b0;
        end
    end

    assign busy        = (r_st != S_IDLE);
    assign o_res_valid = r_ov;
    assign o_res       = r_o;

    `ACE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ACE_ASSERT_IMPL(a_last_idle, i_clk, i_rst_n, o_res_valid && o_res.last && busy,
                     r_st == S_IDLE || r_st == S_HASH)
    `ACE_ASSERT_IMPL(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos < PW'(N))
endmodule
